@@ rtl/hlfb_pkg.sv @@
// hlfb_pkg: constants, slot codes and log type lookup for the HCI log frame builder.
// Used by rtl/hci_log_frame_builder.sv and rtl/hlfb_checker.sv; no dependencies.
package hlfb_pkg;

  localparam logic [7:0] SYNC0 = 8'hF5;
  localparam logic [7:0] SYNC1 = 8'h5A;

  localparam logic [7:0] KIND_CMD = 8'h01;
  localparam logic [7:0] KIND_ACL = 8'h02;
  localparam logic [7:0] KIND_EVT = 8'h04;

  localparam logic [7:0] LOG_CMD_OUT = 8'h01;
  localparam logic [7:0] LOG_ACL_OUT = 8'h02;
  localparam logic [7:0] LOG_ACL_IN  = 8'h04;
  localparam logic [7:0] LOG_EVT_IN  = 8'h08;
  localparam logic [7:0] LOG_NONE    = 8'h00;

  localparam logic [7:0] EVT_MAX  = 8'h3E;
  localparam logic [7:0] EVT_WILD = 8'hFF;

  // byte slots of one word's output, in frame order
  localparam int NUM_SLOTS = 7;
  localparam int SLOT_SYNC0 = 0;
  localparam int SLOT_SYNC1 = 1;
  localparam int SLOT_TYPE  = 2;
  localparam int SLOT_LENLO = 3;
  localparam int SLOT_LENHI = 4;
  localparam int SLOT_DATA  = 5;
  localparam int SLOT_SUM   = 6;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // log type byte, LOG_NONE when the packet is dropped
  function automatic logic [7:0] log_type(input logic [7:0] kind, input logic inb,
                                          input logic has, input logic [7:0] first_b);
    logic [7:0] t;
    t = LOG_NONE;
    if (kind == KIND_EVT && has && first_b > EVT_MAX && first_b != EVT_WILD) begin
      t = LOG_NONE;
    end else if (!inb) begin
      if (kind == KIND_CMD) t = LOG_CMD_OUT;
      else if (kind == KIND_ACL) t = LOG_ACL_OUT;
    end else begin
      if (kind == KIND_ACL) t = LOG_ACL_IN;
      else if (kind == KIND_EVT) t = LOG_EVT_IN;
    end
    return t;
  endfunction

endpackage

@@ rtl/hci_log_frame_builder.sv @@
// hci_log_frame_builder: wraps HCI packets, one byte word at a time, into log frames.
// Depends on rtl/hlfb_pkg.sv.
//
//   channel | signals                                          | dir
//   in      | in_valid/in_ready, packet_kind, inbound,         | in
//           | payload_length, payload_byte, has_byte,          |
//           | first_item, last_item                            |
//   out     | out_valid/out_ready, frame_byte, frame_end       | out
//
// A word is held in an input register and its bytes leave through an output
// register, one per cycle unless out stalls: a plain payload word sends its
// data byte, a first word five header bytes and data, plus a closing checksum.
// Dropped words and words with nothing to send put no byte out.
// The next word is accepted in the cycle the held word's last byte moves out.
// A stall on out holds the output register and back-pressures in.
// rst is synchronous and clears all control state.
module hci_log_frame_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  packet_kind,
  input  logic        inbound,
  input  logic [15:0] payload_length,
  input  logic [7:0]  payload_byte,
  input  logic        has_byte,
  input  logic        first_item,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);

  hlfb_pkg::slot_mask_t mask, mask_next, mask_rest;
  logic [7:0]  h_type;
  logic [15:0] h_len;
  logic [7:0]  h_byte;
  logic        dropping, dropping_next;
  logic [7:0]  running_sum;
  logic        load, accept;
  logic [7:0]  sel_byte;
  logic        sel_end;
  logic [7:0]  in_type;
  logic [7:0]  sum_next;

  assign mask_rest = mask & (mask - hlfb_pkg::slot_mask_t'(1));
  assign load      = (mask != '0) && (!out_valid || out_ready);
  assign in_ready  = (mask == '0) || (load && mask_rest == '0);
  assign accept    = in_valid && in_ready;
  assign in_type   = hlfb_pkg::log_type(packet_kind, inbound, has_byte, payload_byte);

  always_comb begin
    sel_end  = 1'b0;
    sel_byte = h_byte;
    priority if (mask[hlfb_pkg::SLOT_SYNC0]) sel_byte = hlfb_pkg::SYNC0;
    else if (mask[hlfb_pkg::SLOT_SYNC1]) sel_byte = hlfb_pkg::SYNC1;
    else if (mask[hlfb_pkg::SLOT_TYPE])  sel_byte = h_type;
    else if (mask[hlfb_pkg::SLOT_LENLO]) sel_byte = h_len[7:0];
    else if (mask[hlfb_pkg::SLOT_LENHI]) sel_byte = h_len[15:8];
    else if (mask[hlfb_pkg::SLOT_DATA])  sel_byte = h_byte;
    else begin
      sel_byte = running_sum;
      sel_end  = 1'b1;
    end
  end

  always_comb begin
    mask_next     = load ? mask_rest : mask;
    dropping_next = dropping;
    sum_next      = running_sum;
    if (load && !sel_end) sum_next = running_sum + sel_byte;
    if (accept) begin
      if (first_item) begin
        sum_next = '0;
        if (in_type == hlfb_pkg::LOG_NONE) begin
          dropping_next = 1'b1;
          mask_next     = '0;
        end else begin
          dropping_next = 1'b0;
          mask_next     = '0;
          mask_next[hlfb_pkg::SLOT_SYNC0] = 1'b1;
          mask_next[hlfb_pkg::SLOT_SYNC1] = 1'b1;
          mask_next[hlfb_pkg::SLOT_TYPE]  = 1'b1;
          mask_next[hlfb_pkg::SLOT_LENLO] = 1'b1;
          mask_next[hlfb_pkg::SLOT_LENHI] = 1'b1;
          mask_next[hlfb_pkg::SLOT_DATA]  = has_byte;
          mask_next[hlfb_pkg::SLOT_SUM]   = last_item;
        end
      end else begin
        mask_next = '0;
        if (!dropping) begin
          mask_next[hlfb_pkg::SLOT_DATA] = has_byte;
          mask_next[hlfb_pkg::SLOT_SUM]  = last_item;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask        <= '0;
      dropping    <= 1'b0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      mask        <= mask_next;
      dropping    <= dropping_next;
      running_sum <= sum_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_type <= in_type;
      h_len  <= payload_length;
      h_byte <= payload_byte;
    end
    if (load) begin
      frame_byte <= sel_byte;
      frame_end  <= sel_end;
    end
  end

endmodule

@@ rtl/hlfb_checker.sv @@
// hlfb_checker: port-level assertions for hci_log_frame_builder, bound into that module.
// Depends on rtl/hlfb_pkg.sv and rtl/hci_log_frame_builder.sv.
module hlfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  packet_kind,
  input logic        inbound,
  input logic        first_item,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  frame_byte,
  input logic        frame_end
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(frame_end))
    else $error("output word changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // outgoing command opens a frame: output is busy once its first header byte is loaded
  a_cmd_opens: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && first_item && packet_kind == hlfb_pkg::KIND_CMD && !inbound
      |-> ##2 out_valid)
    else $error("logged packet produced no output");

  // nothing held after reset, so a word can be taken at once
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

endmodule

bind hci_log_frame_builder hlfb_checker u_hlfb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .packet_kind (packet_kind),
  .inbound     (inbound),
  .first_item  (first_item),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .frame_byte  (frame_byte),
  .frame_end   (frame_end)
);
